FILE: rtl/pbmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmd_pkg: shared definitions for the balance motor drive PID
// Register indexes, reset values, field widths and multiplier operand sizes.
// ----------------------------------------------------------------------------
package pbmd_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_TARGET_ANGLE   = 3'd0;
   localparam logic [2:0] CSR_GAIN_P         = 3'd1;
   localparam logic [2:0] CSR_GAIN_I         = 3'd2;
   localparam logic [2:0] CSR_GAIN_D         = 3'd3;
   localparam logic [2:0] CSR_INTEGRAL_LIMIT = 3'd4;
   localparam logic [2:0] CSR_TICK_SECONDS   = 3'd5;
   localparam logic [2:0] CSR_TICK_RATE      = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] TICK_SECONDS_RESET = 16'd1311;
   localparam logic [9:0]  TICK_RATE_RESET    = 10'd50;

   localparam int DUTY_MAX_DEFAULT = 999;

   // direction codes
   localparam logic [1:0] DIR_STOP    = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   // shared multiplier: signed A x signed B
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 33;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

FILE: rtl/pbmd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmd_mul: shared signed multiplier
// One signed 18 x 33 bit product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module pbmd_mul (
   input  logic                                 clock,
   input  logic signed [pbmd_pkg::MUL_A_W-1:0]  op_a,
   input  logic signed [pbmd_pkg::MUL_B_W-1:0]  op_b,
   output logic signed [pbmd_pkg::MUL_P_W-1:0]  product_ff
);

   logic signed [pbmd_pkg::MUL_P_W-1:0] product_in;

   assign product_in = pbmd_pkg::MUL_P_W'(op_a) * pbmd_pkg::MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

FILE: rtl/pid_balance_motor_drive_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_balance_motor_drive_unit: tilt PID with clamped integral
// Turns one measured tilt angle per control tick into a saturated motor
// command, a direction code and a PWM duty.
// ----------------------------------------------------------------------------
// Each angle beat runs through a short sequencer that feeds one registered
// 18 x 33 bit multiplier five times: error times dt for the integral, error
// difference times tick rate for the derivative, then the three gain products,
// which are summed at 2^-32 scale, truncated toward zero and saturated to
// +/- DUTY_MAX. A beat is taken only while the sequencer is idle; it then
// steps through MUL_INT, INTEG, CLAMP, ACC_P, ACC_I, ACC_D, ROUND and FINISH,
// and the next angle is taken only after FINISH has passed the result to the
// output register. A finished result sits in the output register and does
// not block the next angle; only a second result waiting on it stalls the
// sequencer. Write the registers only while no angle is in flight.
module pid_balance_motor_drive_unit #(
   parameter int DUTY_MAX = pbmd_pkg::DUTY_MAX_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_we,
   input  logic [pbmd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbmd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // angle input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // [15:0] measured_angle
   // drive result
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata   // [10:0] drive,
                                                           // [12:11] direction,
                                                           // [22:13] duty
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_INT,
      S_INTEG,
      S_CLAMP,
      S_ACC_P,
      S_ACC_I,
      S_ACC_D,
      S_ROUND,
      S_FINISH
   } state_type;

   localparam logic signed [32:0] DMAX = 33'(DUTY_MAX);

   state_type state_ff;

   // configuration registers
   logic signed [15:0] target_ff;
   logic signed [15:0] gain_p_ff;
   logic signed [15:0] gain_i_ff;
   logic signed [15:0] gain_d_ff;
   logic        [14:0] limit_ff;
   logic        [15:0] tick_seconds_ff;
   logic        [9:0]  tick_rate_ff;

   // controller state
   logic signed [31:0] integral_ff;
   logic signed [16:0] last_error_ff;

   // working registers
   logic signed [16:0] err_ff;
   logic signed [17:0] diff_ff;
   logic signed [34:0] sum_ff;
   logic signed [28:0] deriv_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] quot_ff;

   logic               rsp_tvalid_ff;
   logic [23:0]        rsp_tdata_ff;

   // combinational next values
   logic signed [16:0] err_in;
   logic signed [17:0] diff_in;
   logic signed [34:0] sum_in;
   logic signed [34:0] lim_in;
   logic signed [31:0] integral_in;
   logic signed [31:0] quot_in;
   logic signed [32:0] sat_in;
   logic signed [32:0] mag_in;
   logic [1:0]         dir_in;

   logic signed [pbmd_pkg::MUL_A_W-1:0] mul_a;
   logic signed [pbmd_pkg::MUL_B_W-1:0] mul_b;
   logic signed [pbmd_pkg::MUL_P_W-1:0] product_ff;

   logic req_beat;
   logic out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign err_in  = 17'(target_ff) - 17'($signed(req_tdata));
   assign diff_in = 18'(err_in) - 18'(last_error_ff);
   assign sum_in  = 35'(integral_ff) + 35'($signed(product_ff[33:0]));
   assign lim_in  = $signed({4'b0, limit_ff, 16'b0});

   always_comb begin
      if (sum_ff > lim_in) begin
         integral_in = 32'(lim_in);
      end else if (sum_ff < -lim_in) begin
         integral_in = 32'(-lim_in);
      end else begin
         integral_in = 32'(sum_ff);
      end
   end

   // truncate toward zero: bump the floor when negative with a fraction left
   assign quot_in = acc_ff[63:32] + {31'b0, (acc_ff[63] && (|acc_ff[31:0]))};

   always_comb begin
      if (33'(quot_ff) > DMAX) begin
         sat_in = DMAX;
      end else if (33'(quot_ff) < -DMAX) begin
         sat_in = -DMAX;
      end else begin
         sat_in = 33'(quot_ff);
      end
      if (sat_in > 33'sd0) begin
         dir_in = pbmd_pkg::DIR_FORWARD;
         mag_in = sat_in;
      end else if (sat_in < 33'sd0) begin
         dir_in = pbmd_pkg::DIR_REVERSE;
         mag_in = -sat_in;
      end else begin
         dir_in = pbmd_pkg::DIR_STOP;
         mag_in = 33'sd0;
      end
   end

   // multiplier operand select, product is registered and used in the next state
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_INT: begin
            mul_a = 18'(err_ff);
            mul_b = $signed({17'b0, tick_seconds_ff});
         end
         S_INTEG: begin
            mul_a = diff_ff;
            mul_b = $signed({23'b0, tick_rate_ff});
         end
         S_CLAMP: begin
            mul_a = 18'(gain_p_ff);
            mul_b = 33'(err_ff);
         end
         S_ACC_P: begin
            mul_a = 18'(gain_i_ff);
            mul_b = 33'(integral_ff);
         end
         S_ACC_I: begin
            mul_a = 18'(gain_d_ff);
            mul_b = 33'(deriv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   pbmd_mul u_mul (
      .clock      (clock),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .product_ff (product_ff)
   );

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff       <= '0;
         gain_p_ff       <= '0;
         gain_i_ff       <= '0;
         gain_d_ff       <= '0;
         limit_ff        <= '0;
         tick_seconds_ff <= pbmd_pkg::TICK_SECONDS_RESET;
         tick_rate_ff    <= pbmd_pkg::TICK_RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pbmd_pkg::CSR_TARGET_ANGLE:   target_ff       <= $signed(csr_wdata);
            pbmd_pkg::CSR_GAIN_P:         gain_p_ff       <= $signed(csr_wdata);
            pbmd_pkg::CSR_GAIN_I:         gain_i_ff       <= $signed(csr_wdata);
            pbmd_pkg::CSR_GAIN_D:         gain_d_ff       <= $signed(csr_wdata);
            pbmd_pkg::CSR_INTEGRAL_LIMIT: limit_ff        <= csr_wdata[14:0];
            pbmd_pkg::CSR_TICK_SECONDS:   tick_seconds_ff <= csr_wdata;
            pbmd_pkg::CSR_TICK_RATE:      tick_rate_ff    <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               err_ff  <= err_in;
               diff_ff <= diff_in;
            end
         end
         S_INTEG: sum_ff   <= sum_in;
         S_CLAMP: deriv_ff <= $signed(product_ff[28:0]);
         S_ACC_P: acc_ff   <= 64'($signed({product_ff[32:0], 16'b0}));
         S_ACC_I: acc_ff   <= acc_ff + 64'($signed(product_ff[47:0]));
         S_ACC_D: acc_ff   <= acc_ff + 64'($signed({product_ff[44:0], 16'b0}));
         S_ROUND: quot_ff  <= quot_in;
         default: begin
         end
      endcase
   end

   // sequencer, controller state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         integral_ff   <= '0;
         last_error_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (state_ff == S_FINISH && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  last_error_ff <= err_in;
                  state_ff      <= S_MUL_INT;
               end
            end
            S_MUL_INT: state_ff <= S_INTEG;
            S_INTEG:   state_ff <= S_CLAMP;
            S_CLAMP: begin
               integral_ff <= integral_in;
               state_ff    <= S_ACC_P;
            end
            S_ACC_P:   state_ff <= S_ACC_I;
            S_ACC_I:   state_ff <= S_ACC_D;
            S_ACC_D:   state_ff <= S_ROUND;
            S_ROUND:   state_ff <= S_FINISH;
            S_FINISH: begin
               // hold until the output register can take the beat
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && out_free) begin
         rsp_tdata_ff <= {1'b0, mag_in[9:0], dir_in, sat_in[10:0]};
      end
   end

   // checks
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while sequencer busy");

   a_integral_clamped: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACC_P |-> (35'(integral_ff) <= lim_in) && (35'(integral_ff) >= -lim_in))
      else $error("integral outside clamp after update");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside finish step");

   a_stop_means_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12:11] == pbmd_pkg::DIR_STOP
      |-> rsp_tdata[22:13] == 10'd0 && rsp_tdata[10:0] == 11'd0)
      else $error("stop code with nonzero drive");

endmodule
